// ----- hdl/ttcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types and constants for the text console cell buffer.
// ----------------------------------------------------------------------------
package ttcb_pkg;

    localparam int MaxColumnsDef = 128;
    localparam int MaxRowsDef    = 64;
    localparam int TabStepDef    = 4;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 8;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] REG_SCREEN_COLUMNS = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SCREEN_ROWS    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_REGION_LEFT    = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_REGION_TOP     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_REGION_COLUMNS = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_REGION_ROWS    = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_TEXT_ATTRIBUTE = 3'd6;

    localparam logic [7:0] RST_SCREEN_COLUMNS = 8'd80;
    localparam logic [6:0] RST_SCREEN_ROWS    = 7'd25;
    localparam logic [6:0] RST_REGION_LEFT    = 7'd0;
    localparam logic [5:0] RST_REGION_TOP     = 6'd0;
    localparam logic [7:0] RST_REGION_COLUMNS = 8'd80;
    localparam logic [6:0] RST_REGION_ROWS    = 7'd25;
    localparam logic [7:0] RST_TEXT_ATTRIBUTE = 8'h07;

    // operation codes
    localparam logic [2:0] OP_PRINT  = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_SCROLL = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_BLANK   = 8'h20;

    localparam logic [15:0] RESET_CELL = 16'h0720;

    typedef enum logic [3:0] {
        CMD_PRINT,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_TAB,
        CMD_CLEAR,
        CMD_SCROLL,
        CMD_WRITE,
        CMD_READ,
        CMD_IGNORE
    } cmd_kind_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] char_code;
        logic [6:0] cell_column;
        logic [5:0] cell_row;
    } item_t;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [5:0]  cursor_row;
        logic [15:0] cell_value;
        logic        did_scroll;
        logic        ignored;
    } result_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] char_code;
        logic [6:0] cell_column;
        logic [5:0] cell_row;
    } cmd_t;

endpackage

// ----- hdl/ttcb_ram.sv -----
// ----------------------------------------------------------------------------
// ttcb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/ttcb_front.sv -----
// ----------------------------------------------------------------------------
// ttcb_front
// Accepts input words, decodes them into commands, two-entry command queue.
// ----------------------------------------------------------------------------
module ttcb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  ttcb_pkg::item_t item,
    input  logic            region_off,
    input  logic            busy,
    output logic            cmd_valid,
    output ttcb_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);

    ttcb_pkg::cmd_t q_reg [2];
    logic           wptr_reg;
    logic           rptr_reg;
    logic [1:0]     count_reg;
    ttcb_pkg::cmd_t decoded;
    logic           accept;
    logic           take;

    always_comb
    begin
        decoded.char_code   = item.char_code;
        decoded.cell_column = item.cell_column;
        decoded.cell_row    = item.cell_row;
        case (item.op)
            ttcb_pkg::OP_PRINT:
            begin
                if (region_off)
                    decoded.kind = ttcb_pkg::CMD_IGNORE;
                else if (item.char_code == ttcb_pkg::CH_NEWLINE)
                    decoded.kind = ttcb_pkg::CMD_NEWLINE;
                else if (item.char_code == ttcb_pkg::CH_RETURN)
                    decoded.kind = ttcb_pkg::CMD_RETURN;
                else if (item.char_code == ttcb_pkg::CH_TAB)
                    decoded.kind = ttcb_pkg::CMD_TAB;
                else
                    decoded.kind = ttcb_pkg::CMD_PRINT;
            end
            ttcb_pkg::OP_CLEAR:
                decoded.kind = region_off ? ttcb_pkg::CMD_IGNORE : ttcb_pkg::CMD_CLEAR;
            ttcb_pkg::OP_SCROLL:
                decoded.kind = region_off ? ttcb_pkg::CMD_IGNORE : ttcb_pkg::CMD_SCROLL;
            ttcb_pkg::OP_WRITE:
                decoded.kind = ttcb_pkg::CMD_WRITE;
            ttcb_pkg::OP_READ:
                decoded.kind = ttcb_pkg::CMD_READ;
            default:
                decoded.kind = ttcb_pkg::CMD_IGNORE;
        endcase
    end

    assign full      = (count_reg == 2'd2) || busy;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rptr_reg];
    assign take      = cmd_pop && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                q_reg[wptr_reg] <= decoded;
                wptr_reg        <= ~wptr_reg;
            end
            if (take)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(accept) - 2'(take);
        end
    end

endmodule

// ----- hdl/ttcb_back.sv -----
// ----------------------------------------------------------------------------
// ttcb_back
// Command sequencer: cursor, cell store, region sweeps and result queue.
// ----------------------------------------------------------------------------
module ttcb_back #(
    parameter int MAX_COLUMNS = ttcb_pkg::MaxColumnsDef,
    parameter int MAX_ROWS    = ttcb_pkg::MaxRowsDef,
    parameter int TAB_STEP    = ttcb_pkg::TabStepDef
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  ttcb_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  scr_w,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     scr_h,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  reg_w,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     reg_h,
    input  logic [6:0]                        left,
    input  logic [5:0]                        top,
    input  logic [7:0]                        attr,
    output logic                              busy,
    output logic                              empty,
    input  logic                              pop,
    output ttcb_pkg::result_t                 result
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int LCW   = (CW > 7) ? CW : 7;
    localparam int LRW   = (RW > 6) ? RW : 6;
    localparam int SXW   = LCW + 1;
    localparam int SYW   = LRW + 1;
    localparam int BW    = SYW + CW;
    localparam int BW1   = BW + 1;
    localparam int XSW   = $clog2(MAX_COLUMNS + TAB_STEP + 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SETUP,
        S_SWEEP
    } state_t;

    typedef enum logic [1:0] {
        SW_CLEAR,
        SW_COPY,
        SW_FILL
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [AW-1:0]     init_cnt_reg;
    ttcb_pkg::cmd_t    cmd_reg;
    logic              hit_reg;
    logic [AW-1:0]     addr_reg;
    logic [CW-1:0]     cursor_x_reg;
    logic [RW-1:0]     cursor_y_reg;
    logic              res_scroll_reg;
    logic              res_ign_reg;
    logic [CW-1:0]     c_reg;
    logic [RW-1:0]     r_reg;
    logic [BW-1:0]     row_base_reg;
    logic              st_we_reg;
    logic [AW-1:0]     st_addr_reg;
    logic              st_copy_reg;
    logic [15:0]       st_data_reg;

    ttcb_pkg::result_t q_reg [2];
    logic              wptr_reg;
    logic              rptr_reg;
    logic [1:0]        count_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [15:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [15:0]       ram_rdata;

    logic [LCW-1:0]    p_col;
    logic [LRW-1:0]    p_row;
    logic [SXW-1:0]    p_sx;
    logic [SYW-1:0]    p_sy;
    logic              p_hit;
    logic [AW-1:0]     p_addr;

    logic [SXW-1:0]    s_sx;
    logic [SYW-1:0]    s_sy;
    logic              s_on;
    logic [BW1-1:0]    s_addr;
    logic              c_last;
    logic              r_last;
    logic              sweep_done;
    logic [RW-1:0]     r0;
    logic [SYW-1:0]    sy0;

    logic              k_print;
    logic              k_tab;
    logic [XSW-1:0]    x_inc;
    logic [RW-1:0]     y_inc;
    logic              y_wrap;
    logic              ex_newline;
    logic              ex_ign;
    logic              ex_push;
    logic [CW-1:0]     ex_x;
    logic [RW-1:0]     ex_y;

    logic              push_en;
    ttcb_pkg::result_t push_word;
    logic              popped;

    ttcb_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // single-cell locate, from the queue head
    always_comb
    begin
        if (cmd.kind == ttcb_pkg::CMD_PRINT)
        begin
            p_col = LCW'(cursor_x_reg);
            p_row = LRW'(cursor_y_reg);
        end
        else
        begin
            p_col = LCW'(cmd.cell_column);
            p_row = LRW'(cmd.cell_row);
        end
        p_sx   = SXW'(left) + SXW'(p_col);
        p_sy   = SYW'(top) + SYW'(p_row);
        p_hit  = (p_col < LCW'(reg_w)) && (p_row < LRW'(reg_h))
                 && (p_sx < SXW'(scr_w)) && (p_sy < SYW'(scr_h));
        p_addr = AW'(BW'(p_sy) * BW'(scr_w) + BW'(p_sx));
    end

    // sweep walk
    always_comb
    begin
        s_sx       = SXW'(left) + SXW'(c_reg);
        s_sy       = SYW'(top) + SYW'(r_reg);
        s_on       = (s_sx < SXW'(scr_w)) && (s_sy < SYW'(scr_h));
        s_addr     = BW1'(row_base_reg) + BW1'(s_sx);
        c_last     = (c_reg == reg_w - CW'(1));
        r_last     = (r_reg == reg_h - RW'(1));
        sweep_done = (state_reg == S_SWEEP) && c_last
                     && ((phase_reg == SW_FILL) || ((phase_reg == SW_CLEAR) && r_last));
        case (phase_reg)
            SW_COPY:  r0 = RW'(1);
            SW_FILL:  r0 = reg_h - RW'(1);
            default:  r0 = '0;
        endcase
        sy0 = SYW'(top) + SYW'(r0);
    end

    // cursor update for single-cell commands
    always_comb
    begin
        k_print = (cmd_reg.kind == ttcb_pkg::CMD_PRINT);
        k_tab   = (cmd_reg.kind == ttcb_pkg::CMD_TAB);
        x_inc   = XSW'(cursor_x_reg) + (k_tab ? XSW'(TAB_STEP) : XSW'(1));
        y_inc   = cursor_y_reg + RW'(1);
        y_wrap  = (y_inc >= reg_h);
        ex_newline = (cmd_reg.kind == ttcb_pkg::CMD_NEWLINE)
                     || ((k_print || k_tab) && (x_inc >= XSW'(reg_w)));
        ex_ign  = ((k_print || cmd_reg.kind == ttcb_pkg::CMD_WRITE
                    || cmd_reg.kind == ttcb_pkg::CMD_READ) && !hit_reg)
                  || (cmd_reg.kind == ttcb_pkg::CMD_IGNORE);
        ex_push = (state_reg == S_EXEC) && !(ex_newline && y_wrap)
                  && !((cmd_reg.kind == ttcb_pkg::CMD_READ) && hit_reg);
        if (ex_newline)
        begin
            ex_x = '0;
            ex_y = y_inc;
        end
        else if (k_print || k_tab)
        begin
            ex_x = CW'(x_inc);
            ex_y = cursor_y_reg;
        end
        else
        begin
            ex_x = cursor_x_reg;
            ex_y = cursor_y_reg;
        end
    end

    // result push
    always_comb
    begin
        push_en   = 1'b0;
        push_word = '0;
        if (ex_push)
        begin
            push_en                 = 1'b1;
            push_word.cursor_column = 7'(ex_x);
            push_word.cursor_row    = 6'(ex_y);
            push_word.ignored       = ex_ign;
        end
        else if (state_reg == S_READ)
        begin
            push_en                 = 1'b1;
            push_word.cursor_column = 7'(cursor_x_reg);
            push_word.cursor_row    = 6'(cursor_y_reg);
            push_word.cell_value    = ram_rdata;
        end
        else if (sweep_done)
        begin
            push_en                 = 1'b1;
            push_word.cursor_column = 7'(cursor_x_reg);
            push_word.cursor_row    = 6'(cursor_y_reg);
            push_word.did_scroll    = res_scroll_reg;
            push_word.ignored       = res_ign_reg;
        end
    end

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid && (count_reg != 2'd2);
    assign busy    = (state_reg == S_INIT);
    assign empty   = (count_reg == 2'd0);
    assign result  = q_reg[rptr_reg];
    assign popped  = pop && !empty;

    assign ram_we    = (state_reg == S_INIT) ? 1'b1 : st_we_reg;
    assign ram_waddr = (state_reg == S_INIT) ? init_cnt_reg : st_addr_reg;
    assign ram_wdata = (state_reg == S_INIT) ? ttcb_pkg::RESET_CELL
                     : (st_copy_reg ? ram_rdata : st_data_reg);
    assign ram_raddr = (state_reg == S_SWEEP) ? AW'(s_addr) : addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            phase_reg      <= SW_CLEAR;
            init_cnt_reg   <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            res_scroll_reg <= 1'b0;
            res_ign_reg    <= 1'b0;
            st_we_reg      <= 1'b0;
            wptr_reg       <= 1'b0;
            rptr_reg       <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (push_en)
            begin
                q_reg[wptr_reg] <= push_word;
                wptr_reg        <= ~wptr_reg;
            end
            if (popped)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push_en) - 2'(popped);

            case (state_reg)
                S_INIT:
                begin
                    st_we_reg    <= 1'b0;
                    init_cnt_reg <= init_cnt_reg + AW'(1);
                    if (init_cnt_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    st_we_reg <= 1'b0;
                    if (cmd_pop)
                    begin
                        cmd_reg  <= cmd;
                        hit_reg  <= p_hit;
                        addr_reg <= p_addr;
                        case (cmd.kind)
                            ttcb_pkg::CMD_CLEAR:
                            begin
                                cursor_x_reg   <= '0;
                                cursor_y_reg   <= '0;
                                res_scroll_reg <= 1'b0;
                                res_ign_reg    <= 1'b0;
                                phase_reg      <= SW_CLEAR;
                                state_reg      <= S_SETUP;
                            end
                            ttcb_pkg::CMD_SCROLL:
                            begin
                                res_scroll_reg <= 1'b1;
                                res_ign_reg    <= 1'b0;
                                phase_reg      <= (reg_h == RW'(1)) ? SW_FILL : SW_COPY;
                                state_reg      <= S_SETUP;
                            end
                            default:
                                state_reg <= S_EXEC;
                        endcase
                    end
                end
                S_EXEC:
                begin
                    st_we_reg <= (k_print || cmd_reg.kind == ttcb_pkg::CMD_WRITE) && hit_reg;
                    if ((k_print || cmd_reg.kind == ttcb_pkg::CMD_WRITE) && hit_reg)
                    begin
                        st_addr_reg <= addr_reg;
                        st_copy_reg <= 1'b0;
                        st_data_reg <= {attr, cmd_reg.char_code};
                    end
                    cursor_x_reg <= ex_x;
                    if (ex_newline && y_wrap)
                    begin
                        cursor_y_reg   <= reg_h - RW'(1);
                        res_scroll_reg <= 1'b1;
                        res_ign_reg    <= ex_ign;
                        phase_reg      <= (reg_h == RW'(1)) ? SW_FILL : SW_COPY;
                        state_reg      <= S_SETUP;
                    end
                    else
                    begin
                        cursor_y_reg <= ex_y;
                        if ((cmd_reg.kind == ttcb_pkg::CMD_READ) && hit_reg)
                            state_reg <= S_READ;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    st_we_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_SETUP:
                begin
                    st_we_reg    <= 1'b0;
                    c_reg        <= '0;
                    r_reg        <= r0;
                    row_base_reg <= BW'(sy0) * BW'(scr_w);
                    state_reg    <= S_SWEEP;
                end
                S_SWEEP:
                begin
                    st_we_reg   <= s_on;
                    st_copy_reg <= (phase_reg == SW_COPY);
                    st_data_reg <= {attr, ttcb_pkg::CH_BLANK};
                    if (phase_reg == SW_COPY)
                        st_addr_reg <= AW'(s_addr - BW1'(scr_w));
                    else
                        st_addr_reg <= AW'(s_addr);
                    if (c_last)
                    begin
                        c_reg <= '0;
                        if (phase_reg == SW_COPY && r_last)
                            phase_reg <= SW_FILL;
                        else if (sweep_done)
                            state_reg <= S_IDLE;
                        else
                        begin
                            r_reg        <= r_reg + RW'(1);
                            row_base_reg <= row_base_reg + BW'(scr_w);
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + CW'(1);
                    end
                end
                default:
                begin
                    st_we_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/text_console_cell_buffer.sv -----
// ----------------------------------------------------------------------------
// text_console_cell_buffer
// Text-mode screen store with one cursor region, print/clear/scroll/poke/peek.
// ----------------------------------------------------------------------------
// Input words enter through push/full and are taken when push is high and
// full is low. Each word yields exactly one result word, presented while
// empty is low and taken on pop. Registers are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce this. Clear and scroll walk
// the region one cell per cycle through the single write port of the
// store, and a print that wraps off the bottom row adds such a scroll.
// A two-entry command queue sits in front, a two-entry result queue behind,
// so input keeps flowing while results wait; if pop stays low the result
// queue fills, the sequencer halts and full rises once the command queue
// fills. After reset the store is filled with blank cells, one cell per
// cycle over all MAX_COLUMNS * MAX_ROWS cells (8192 at default); full stays
// high meanwhile. Registers return to their defaults, cursor to home.
// ----------------------------------------------------------------------------
module text_console_cell_buffer #(
    parameter int MAX_COLUMNS = ttcb_pkg::MaxColumnsDef,
    parameter int MAX_ROWS    = ttcb_pkg::MaxRowsDef,
    parameter int TAB_STEP    = ttcb_pkg::TabStepDef
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  ttcb_pkg::item_t                       item,
    output logic                                  empty,
    input  logic                                  pop,
    output ttcb_pkg::result_t                     result,
    input  logic                                  cfg_write,
    input  logic [ttcb_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [ttcb_pkg::CfgDataWidth-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [7:0]     scr_cols_reg;
    logic [6:0]     scr_rows_reg;
    logic [6:0]     left_reg;
    logic [5:0]     top_reg;
    logic [7:0]     reg_cols_reg;
    logic [6:0]     reg_rows_reg;
    logic [7:0]     attr_reg;

    logic [CW-1:0]  scr_w;
    logic [RW-1:0]  scr_h;
    logic [CW-1:0]  reg_w;
    logic [RW-1:0]  reg_h;
    logic           region_off;
    logic           busy;
    logic           cmd_valid;
    logic           cmd_pop;
    ttcb_pkg::cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_cols_reg <= ttcb_pkg::RST_SCREEN_COLUMNS;
            scr_rows_reg <= ttcb_pkg::RST_SCREEN_ROWS;
            left_reg     <= ttcb_pkg::RST_REGION_LEFT;
            top_reg      <= ttcb_pkg::RST_REGION_TOP;
            reg_cols_reg <= ttcb_pkg::RST_REGION_COLUMNS;
            reg_rows_reg <= ttcb_pkg::RST_REGION_ROWS;
            attr_reg     <= ttcb_pkg::RST_TEXT_ATTRIBUTE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ttcb_pkg::REG_SCREEN_COLUMNS: scr_cols_reg <= cfg_data;
                ttcb_pkg::REG_SCREEN_ROWS:    scr_rows_reg <= cfg_data[6:0];
                ttcb_pkg::REG_REGION_LEFT:    left_reg     <= cfg_data[6:0];
                ttcb_pkg::REG_REGION_TOP:     top_reg      <= cfg_data[5:0];
                ttcb_pkg::REG_REGION_COLUMNS: reg_cols_reg <= cfg_data;
                ttcb_pkg::REG_REGION_ROWS:    reg_rows_reg <= cfg_data[6:0];
                ttcb_pkg::REG_TEXT_ATTRIBUTE: attr_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // sizes saturate at the store geometry
    assign scr_w = (32'(scr_cols_reg) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(scr_cols_reg);
    assign scr_h = (32'(scr_rows_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(scr_rows_reg);
    assign reg_w = (32'(reg_cols_reg) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(reg_cols_reg);
    assign reg_h = (32'(reg_rows_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(reg_rows_reg);
    assign region_off = (reg_w == '0) || (reg_h == '0);

    ttcb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .region_off(region_off),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ttcb_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS),
        .TAB_STEP   (TAB_STEP)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_pop  (cmd_pop),
        .scr_w    (scr_w),
        .scr_h    (scr_h),
        .reg_w    (reg_w),
        .reg_h    (reg_h),
        .left     (left_reg),
        .top      (top_reg),
        .attr     (attr_reg),
        .busy     (busy),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
